### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the serial parameter command parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle
`define SPCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define SPCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SPCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### sv/spcp_pkg.sv
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared types, widths and character codes of the serial command parser.
// ----------------------------------------------------------------------------
package spcp_pkg;

    // Default line length limit in bytes
    localparam int LINE_MAX_DEF = 256;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int FREQ_W    = 20;
    localparam int DUTY_W    = 7;
    localparam int DEAD_W    = 13;
    localparam int ACC_W     = 21;
    localparam int ACC_EXT_W = ACC_W + 4;

    // Accumulator saturation value
    localparam logic [ACC_EXT_W-1:0] ACC_MAX = ACC_EXT_W'((1 << ACC_W) - 1);

    // Character codes
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_EQ  = 8'h3d;
    localparam logic [BYTE_W-1:0] CH_V   = 8'h76;
    localparam logic [BYTE_W-1:0] CH_Z   = 8'h7a;
    localparam logic [BYTE_W-1:0] CH_D   = 8'h64;
    localparam logic [BYTE_W-1:0] CH_0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_ONE = 8'h31;
    localparam logic [BYTE_W-1:0] CH_TWO = 8'h32;

    // Legal value ranges
    localparam logic [ACC_W-1:0] FREQ_LO = ACC_W'(10);
    localparam logic [ACC_W-1:0] FREQ_HI = ACC_W'(1000000);
    localparam logic [ACC_W-1:0] DUTY_LO = ACC_W'(1);
    localparam logic [ACC_W-1:0] DUTY_HI = ACC_W'(99);
    localparam logic [ACC_W-1:0] DEAD_LO = ACC_W'(0);
    localparam logic [ACC_W-1:0] DEAD_HI = ACC_W'(6000);

    // Reset values of the two parameter sets
    localparam logic [FREQ_W-1:0] FREQ_ONE_RST = FREQ_W'(60100);
    localparam logic [DUTY_W-1:0] DUTY_ONE_RST = DUTY_W'(50);
    localparam logic [DEAD_W-1:0] DEAD_ONE_RST = DEAD_W'(150);
    localparam logic [FREQ_W-1:0] FREQ_TWO_RST = FREQ_W'(59100);
    localparam logic [DUTY_W-1:0] DUTY_TWO_RST = DUTY_W'(50);
    localparam logic [DEAD_W-1:0] DEAD_TWO_RST = DEAD_W'(200);

    // Line verdict
    typedef enum logic [1:0] {
        ST_APPLIED   = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Both parameter sets
    typedef struct packed {
        logic [FREQ_W-1:0] freq_one;
        logic [DUTY_W-1:0] duty_one;
        logic [DEAD_W-1:0] dead_one;
        logic [FREQ_W-1:0] freq_two;
        logic [DUTY_W-1:0] duty_two;
        logic [DEAD_W-1:0] dead_two;
    } param_bank_t;

    // One result
    typedef struct packed {
        status_t     status;
        param_bank_t prm;
    } result_t;

endpackage

### sv/spcp_in_stage.sv
// ----------------------------------------------------------------------------
// spcp_in_stage
// Input register: captures one received byte per request.
// ----------------------------------------------------------------------------
module spcp_in_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [spcp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        step,
    output logic                        byte_vld,
    output logic [spcp_pkg::BYTE_W-1:0] byte_out
);
    import spcp_pkg::*;

    logic              vld_reg;
    logic              vld_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              accept;

    // Stall only while a held byte cannot move on
    assign in_stall = vld_reg & ~step;
    assign accept   = in_valid & ~in_stall;
    assign vld_next = accept | (vld_reg & ~step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign byte_vld = vld_reg;
    assign byte_out = byte_reg;

endmodule

### sv/spcp_parser.sv
// ----------------------------------------------------------------------------
// spcp_parser
// Line state, digit accumulator, line verdict and both parameter sets.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spcp_parser #(
    parameter int LINE_MAX = spcp_pkg::LINE_MAX_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [spcp_pkg::BYTE_W-1:0] rx_byte,
    output logic                        emit,
    output spcp_pkg::result_t           res
);
    import spcp_pkg::*;

    localparam int CNT_W = $clog2(LINE_MAX);

    // Line state
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              cr_reg,   cr_next;
    logic [BYTE_W-1:0] cmd_reg,  cmd_next;
    logic [BYTE_W-1:0] set_reg,  set_next;
    logic [BYTE_W-1:0] sep_reg,  sep_next;
    logic [ACC_W-1:0]  acc_reg,  acc_next;
    logic              derr_reg, derr_next;
    param_bank_t       prm_reg,  prm_next;

    logic [CNT_W:0]     cnt_inc;
    logic [ACC_EXT_W-1:0] acc_mul;
    logic               is_digit;
    logic [ACC_W-1:0]   value;
    logic [ACC_W-1:0]   lo;
    logic [ACC_W-1:0]   hi;
    logic               known;
    status_t            status;

    // LF right after CR closes the line
    assign emit = cr_reg && (rx_byte == CH_LF);

    // Accumulate: acc * 10 + digit, saturating
    assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign acc_mul  = (ACC_EXT_W'(acc_reg) << 3) + (ACC_EXT_W'(acc_reg) << 1)
                    + ACC_EXT_W'(rx_byte[3:0]);
    assign cnt_inc  = {1'b0, cnt_reg} + (CNT_W+1)'(1);

    // Verdict of the stored line
    assign value = derr_reg ? '0 : acc_reg;

    always_comb
    begin
        known = 1'b1;
        lo    = DEAD_LO;
        hi    = DEAD_HI;
        case (cmd_reg)
            CH_V:
            begin
                lo = FREQ_LO;
                hi = FREQ_HI;
            end
            CH_Z:
            begin
                lo = DUTY_LO;
                hi = DUTY_HI;
            end
            CH_D:
            begin
                lo = DEAD_LO;
                hi = DEAD_HI;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cnt_reg == '0)
            status = ST_MALFORMED;
        else if (!known)
            status = ST_UNKNOWN;
        else if (cnt_reg < CNT_W'(3))
            status = ST_MALFORMED;
        else if ((value < lo) || (value > hi))
            status = ST_RANGE;
        else if (sep_reg != CH_EQ)
            status = ST_MALFORMED;
        else if ((set_reg != CH_ONE) && (set_reg != CH_TWO))
            status = ST_MALFORMED;
        else
            status = ST_APPLIED;
    end

    // Parameter update on an applied line
    always_comb
    begin
        prm_next = prm_reg;
        if (step && emit && (status == ST_APPLIED))
        begin
            case (cmd_reg)
                CH_V:
                begin
                    if (set_reg == CH_ONE)
                        prm_next.freq_one = value[FREQ_W-1:0];
                    else
                        prm_next.freq_two = value[FREQ_W-1:0];
                end
                CH_Z:
                begin
                    if (set_reg == CH_ONE)
                        prm_next.duty_one = value[DUTY_W-1:0];
                    else
                        prm_next.duty_two = value[DUTY_W-1:0];
                end
                default:
                begin
                    if (set_reg == CH_ONE)
                        prm_next.dead_one = value[DEAD_W-1:0];
                    else
                        prm_next.dead_two = value[DEAD_W-1:0];
                end
            endcase
        end
    end

    assign res.status = status;
    assign res.prm    = prm_next;

    // Line state next value
    always_comb
    begin
        cnt_next  = cnt_reg;
        cr_next   = cr_reg;
        cmd_next  = cmd_reg;
        set_next  = set_reg;
        sep_next  = sep_reg;
        acc_next  = acc_reg;
        derr_next = derr_reg;
        if (step)
        begin
            if (cr_reg || ((rx_byte != CH_CR) && (cnt_inc == (CNT_W+1)'(LINE_MAX))))
            begin
                // Line ends, is dropped or grew too long
                cnt_next  = '0;
                cr_next   = 1'b0;
                cmd_next  = '0;
                set_next  = '0;
                sep_next  = '0;
                acc_next  = '0;
                derr_next = 1'b0;
            end
            else if (rx_byte == CH_CR)
            begin
                cr_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_inc[CNT_W-1:0];
                if (cnt_reg == CNT_W'(0))
                    cmd_next = rx_byte;
                else if (cnt_reg == CNT_W'(1))
                    set_next = rx_byte;
                else if (cnt_reg == CNT_W'(2))
                    sep_next = rx_byte;
                else if (is_digit)
                    acc_next = (acc_mul > ACC_MAX) ? ACC_MAX[ACC_W-1:0]
                                                   : acc_mul[ACC_W-1:0];
                else
                    derr_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            cr_reg           <= 1'b0;
            cmd_reg          <= '0;
            set_reg          <= '0;
            sep_reg          <= '0;
            acc_reg          <= '0;
            derr_reg         <= 1'b0;
            prm_reg.freq_one <= FREQ_ONE_RST;
            prm_reg.duty_one <= DUTY_ONE_RST;
            prm_reg.dead_one <= DEAD_ONE_RST;
            prm_reg.freq_two <= FREQ_TWO_RST;
            prm_reg.duty_two <= DUTY_TWO_RST;
            prm_reg.dead_two <= DEAD_TWO_RST;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            cr_reg   <= cr_next;
            cmd_reg  <= cmd_next;
            set_reg  <= set_next;
            sep_reg  <= sep_next;
            acc_reg  <= acc_next;
            derr_reg <= derr_next;
            prm_reg  <= prm_next;
        end
    end

    // Any byte after CR starts a fresh line
    `SPCP_ASSERT_NEXT(a_cr_clears, clk, rst_n, step && cr_reg, !cr_reg && (cnt_reg == '0), "line state not cleared after CR")
    // A rejected line leaves the parameters alone
    `SPCP_ASSERT_NEXT(a_reject_holds, clk, rst_n, step && emit && (status != ST_APPLIED), $stable(prm_reg), "parameters changed on rejected line")

endmodule

### sv/spcp_out_stage.sv
// ----------------------------------------------------------------------------
// spcp_out_stage
// Result register: holds one line verdict until the sink takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spcp_out_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  spcp_pkg::result_t           res,
    output logic                        out_valid,
    input  logic                        out_stall,
    output spcp_pkg::result_t           res_out
);
    import spcp_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    assign vld_next = load | (vld_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign res_out   = res_reg;

    // A loaded result is offered in the next cycle
    `SPCP_ASSERT_NEXT(a_load_shows, clk, rst_n, load, out_valid, "loaded result not offered")

endmodule

### sv/serial_param_command_parser.sv
// ----------------------------------------------------------------------------
// serial_param_command_parser
// Parses CR LF terminated ASCII lines that set frequency, duty and dead time.
// ----------------------------------------------------------------------------
// Takes one received byte per request and parses lines of the form
// <v|z|d><1|2>=<decimal> ended by CR LF; each completed line gives one result
// with a status and both parameter sets as they stand after the line. One byte
// is taken every cycle unless the input stalls: it is held in the input
// register, parsed by the combinational line logic, and a completed line's
// result is loaded into the result register. The input stalls only when a
// line ends while the result register still holds a result the sink has not
// taken. Lines that reach LINE_MAX bytes are dropped and parsing restarts.
`include "assert_macros.svh"

module serial_param_command_parser #(
    parameter int LINE_MAX = spcp_pkg::LINE_MAX_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [spcp_pkg::BYTE_W-1:0] rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [spcp_pkg::FREQ_W-1:0] freq_set_one,
    output logic [spcp_pkg::DUTY_W-1:0] duty_set_one,
    output logic [spcp_pkg::DEAD_W-1:0] dead_set_one,
    output logic [spcp_pkg::FREQ_W-1:0] freq_set_two,
    output logic [spcp_pkg::DUTY_W-1:0] duty_set_two,
    output logic [spcp_pkg::DEAD_W-1:0] dead_set_two
);
    import spcp_pkg::*;

    logic              byte_vld;
    logic [BYTE_W-1:0] byte_q;
    logic              emit;
    logic              step;
    result_t           res;
    result_t           res_q;

    // Held byte moves on unless it closes a line while the sink stalls a held result
    assign step = byte_vld & (~emit | ~out_valid | ~out_stall);

    spcp_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .step     (step),
        .byte_vld (byte_vld),
        .byte_out (byte_q)
    );

    spcp_parser #(
        .LINE_MAX (LINE_MAX)
    ) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (byte_q),
        .emit    (emit),
        .res     (res)
    );

    spcp_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step & emit),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_q)
    );

    assign status       = res_q.status;
    assign freq_set_one = res_q.prm.freq_one;
    assign duty_set_one = res_q.prm.duty_one;
    assign dead_set_one = res_q.prm.dead_one;
    assign freq_set_two = res_q.prm.freq_two;
    assign duty_set_two = res_q.prm.duty_two;
    assign dead_set_two = res_q.prm.dead_two;

    // Input stalls only behind a blocked result
    `SPCP_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall && emit, "input stalled without blocked result")

endmodule
